/* rtl/source_tokenizer_assert.svh */
// ----------------------------------------------------------------------------
// source_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define STOK_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("source_tokenizer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define STOK_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("source_tokenizer: next-cycle check failed");

`endif

/* rtl/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// Types and constants shared by the source tokenizer modules.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Counter widths; the ports carry each counter cut or padded to 16 bits
  localparam int LINE_WIDTH   = 16;
  localparam int COLUMN_WIDTH = 16;
  localparam int LENGTH_WIDTH = 16;
  localparam int FIELD_WIDTH  = 16;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [LINE_WIDTH-1:0]   line_t;
  typedef logic [COLUMN_WIDTH-1:0] col_t;
  typedef logic [LENGTH_WIDTH-1:0] len_t;
  typedef logic [FIELD_WIDTH-1:0]  field_t;
  typedef logic [FIFO_PTR_W-1:0]   ptr_t;
  typedef logic [FIFO_PTR_W:0]     cnt_t;

  typedef enum logic [3:0] {
    TK_EOF     = 4'd0,
    TK_LET     = 4'd1,
    TK_PRINT   = 4'd2,
    TK_IDENT   = 4'd3,
    TK_NUMBER  = 4'd4,
    TK_STRING  = 4'd5,
    TK_PLUS    = 4'd6,
    TK_MINUS   = 4'd7,
    TK_STAR    = 4'd8,
    TK_SLASH   = 4'd9,
    TK_PERCENT = 4'd10,
    TK_ASSIGN  = 4'd11,
    TK_ERROR   = 4'd12
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TWO_DOTS = 2'd1,
    ERR_BAD_CHAR = 2'd2
  } tok_err_t;

  typedef struct packed {
    tok_kind_t  kind;
    tok_err_t   err;
    field_t     line;
    field_t     col;
    field_t     len;
    logic [7:0] bad;
    logic       last;
  } tok_rec_t;

  // Records produced by one source byte, oldest in rec0
  typedef struct packed {
    logic [1:0] n;
    tok_rec_t   rec0;
    tok_rec_t   rec1;
  } scan_out_t;

endpackage

/* rtl/stok_scan.sv */
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and per-byte decision: up to two token records per byte.
// ----------------------------------------------------------------------------
`include "source_tokenizer_assert.svh"

module stok_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          char_code,
  input  logic                end_of_source,
  output stok_pkg::scan_out_t res
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING
  } mode_t;

  typedef enum logic [3:0] {
    KW_START = 4'd0,
    KW_L     = 4'd1,
    KW_LE    = 4'd2,
    KW_LET   = 4'd3,
    KW_P     = 4'd4,
    KW_PR    = 4'd5,
    KW_PRI   = 4'd6,
    KW_PRIN  = 4'd7,
    KW_PRINT = 4'd8,
    KW_NONE  = 4'd15
  } kw_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic kw_t kw_step(kw_t m, logic [7:0] c);
    kw_t r;
    r = KW_NONE;
    unique case (m)
      KW_START: r = (c == "l") ? KW_L : ((c == "p") ? KW_P : KW_NONE);
      KW_L:     r = (c == "e") ? KW_LE : KW_NONE;
      KW_LE:    r = (c == "t") ? KW_LET : KW_NONE;
      KW_P:     r = (c == "r") ? KW_PR : KW_NONE;
      KW_PR:    r = (c == "i") ? KW_PRI : KW_NONE;
      KW_PRI:   r = (c == "n") ? KW_PRIN : KW_NONE;
      KW_PRIN:  r = (c == "t") ? KW_PRINT : KW_NONE;
      default:  r = KW_NONE;
    endcase
    return r;
  endfunction

  function automatic stok_pkg::tok_rec_t mk_rec(stok_pkg::tok_kind_t k, stok_pkg::tok_err_t e,
                                                stok_pkg::field_t ln, stok_pkg::field_t cl,
                                                stok_pkg::field_t lg, logic [7:0] b);
    stok_pkg::tok_rec_t r;
    r.kind = k;
    r.err  = e;
    r.line = ln;
    r.col  = cl;
    r.len  = lg;
    r.bad  = b;
    r.last = 1'b0;
    return r;
  endfunction

  mode_t             mode, mode_next;
  stok_pkg::line_t   line_count, line_next;
  stok_pkg::col_t    column_count, column_next;
  stok_pkg::line_t   token_line, token_line_next;
  stok_pkg::col_t    token_column, token_column_next;
  stok_pkg::len_t    token_length, token_length_next;
  logic              seen_dot, seen_dot_next;
  kw_t               keyword_match, keyword_match_next;
  logic              halted, halted_next;

  logic               eos, is_alpha, is_digit, is_space, is_word, do_adv, go_idle;
  logic               p_emit, i_emit;
  stok_pkg::tok_rec_t p_rec, i_rec;
  stok_pkg::tok_kind_t op_kind, id_kind;
  stok_pkg::len_t     len_inc;
  stok_pkg::field_t   tl16, tc16, tk16, lc16, cc16;

  assign eos      = end_of_source || (char_code == 8'h00);
  assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
  assign is_digit = (char_code >= "0" && char_code <= "9");
  assign is_space = (char_code == CH_SPACE) || (char_code >= 8'h09 && char_code <= 8'h0D);
  assign is_word  = is_alpha || is_digit || (char_code == CH_UNDER);
  assign len_inc  = (token_length == '1) ? token_length : token_length + 1'b1;

  assign tl16 = stok_pkg::field_t'(token_line);
  assign tc16 = stok_pkg::field_t'(token_column);
  assign tk16 = stok_pkg::field_t'(token_length);
  assign lc16 = stok_pkg::field_t'(line_count);
  assign cc16 = stok_pkg::field_t'(column_count);

  assign id_kind = (keyword_match == KW_LET)   ? stok_pkg::TK_LET :
                   (keyword_match == KW_PRINT) ? stok_pkg::TK_PRINT : stok_pkg::TK_IDENT;

  always_comb begin
    unique case (char_code)
      CH_PLUS:  op_kind = stok_pkg::TK_PLUS;
      CH_MINUS: op_kind = stok_pkg::TK_MINUS;
      CH_STAR:  op_kind = stok_pkg::TK_STAR;
      CH_SLASH: op_kind = stok_pkg::TK_SLASH;
      CH_PCT:   op_kind = stok_pkg::TK_PERCENT;
      CH_EQ:    op_kind = stok_pkg::TK_ASSIGN;
      default:  op_kind = stok_pkg::TK_ERROR;
    endcase
  end

  always_comb begin
    mode_next          = mode;
    line_next          = line_count;
    column_next        = column_count;
    token_line_next    = token_line;
    token_column_next  = token_column;
    token_length_next  = token_length;
    seen_dot_next      = seen_dot;
    keyword_match_next = keyword_match;
    halted_next        = halted;
    p_emit  = 1'b0;
    i_emit  = 1'b0;
    p_rec   = '0;
    i_rec   = '0;
    do_adv  = 1'b0;
    go_idle = 1'b0;

    if (fire && !halted) begin
      // Extend or close the token in progress
      unique case (mode)
        MODE_IDENT: begin
          if (!eos && is_word) begin
            token_length_next  = len_inc;
            keyword_match_next = kw_step(keyword_match, char_code);
            do_adv             = 1'b1;
          end else begin
            p_emit    = 1'b1;
            p_rec     = mk_rec(id_kind, stok_pkg::ERR_NONE, tl16, tc16, tk16, 8'h00);
            mode_next = MODE_IDLE;
            go_idle   = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!eos && (is_digit || char_code == CH_UNDER || char_code == CH_DOT)) begin
            if (char_code == CH_DOT && seen_dot) begin
              p_emit      = 1'b1;
              p_rec       = mk_rec(stok_pkg::TK_ERROR, stok_pkg::ERR_TWO_DOTS, tl16, tc16,
                                   '0, 8'h00);
              halted_next = 1'b1;
            end else begin
              if (char_code == CH_DOT) begin
                seen_dot_next = 1'b1;
              end
              if (char_code != CH_UNDER) begin
                token_length_next = len_inc;
              end
              do_adv = 1'b1;
            end
          end else begin
            p_emit    = 1'b1;
            p_rec     = mk_rec(stok_pkg::TK_NUMBER, stok_pkg::ERR_NONE, tl16, tc16, tk16,
                               8'h00);
            mode_next = MODE_IDLE;
            go_idle   = 1'b1;
          end
        end
        MODE_STRING: begin
          if (eos || char_code == CH_QUOTE) begin
            p_emit    = 1'b1;
            p_rec     = mk_rec(stok_pkg::TK_STRING, stok_pkg::ERR_NONE, tl16, tc16, tk16,
                               8'h00);
            mode_next = MODE_IDLE;
            go_idle   = eos;
            do_adv    = !eos;
          end else begin
            token_length_next = len_inc;
            do_adv            = 1'b1;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      // Scan the byte from idle
      if (go_idle) begin
        if (eos) begin
          i_emit = 1'b1;
          i_rec  = mk_rec(stok_pkg::TK_EOF, stok_pkg::ERR_NONE, lc16, cc16, '0, 8'h00);
        end else if (is_space) begin
          do_adv = 1'b1;
        end else if (is_alpha || is_digit || char_code == CH_UNDER || char_code == CH_QUOTE) begin
          token_line_next   = line_count;
          token_column_next = column_count;
          token_length_next = (char_code == CH_QUOTE) ? '0 : stok_pkg::len_t'(1);
          seen_dot_next     = 1'b0;
          do_adv            = 1'b1;
          if (char_code == CH_QUOTE) begin
            mode_next = MODE_STRING;
          end else if (is_digit) begin
            mode_next = MODE_NUMBER;
          end else begin
            mode_next          = MODE_IDENT;
            keyword_match_next = kw_step(KW_START, char_code);
          end
        end else if (op_kind != stok_pkg::TK_ERROR) begin
          i_emit = 1'b1;
          i_rec  = mk_rec(op_kind, stok_pkg::ERR_NONE, lc16, cc16, stok_pkg::field_t'(1),
                          8'h00);
          do_adv = 1'b1;
        end else begin
          i_emit      = 1'b1;
          i_rec       = mk_rec(stok_pkg::TK_ERROR, stok_pkg::ERR_BAD_CHAR, lc16, cc16, '0,
                               char_code);
          halted_next = 1'b1;
        end
      end

      // Move the position past the consumed byte
      if (do_adv) begin
        if (char_code == CH_LF) begin
          line_next   = (line_count == '1) ? line_count : line_count + 1'b1;
          column_next = stok_pkg::col_t'(1);
        end else begin
          column_next = (column_count == '1) ? column_count : column_count + 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.n         = {1'b0, p_emit} + {1'b0, i_emit};
    res.rec0      = p_emit ? p_rec : i_rec;
    res.rec0.last = !(p_emit && i_emit);
    res.rec1      = i_rec;
    res.rec1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      line_count    <= stok_pkg::line_t'(1);
      column_count  <= stok_pkg::col_t'(1);
      token_line    <= '0;
      token_column  <= '0;
      token_length  <= '0;
      seen_dot      <= 1'b0;
      keyword_match <= KW_START;
      halted        <= 1'b0;
    end else begin
      mode          <= mode_next;
      line_count    <= line_next;
      column_count  <= column_next;
      token_line    <= token_line_next;
      token_column  <= token_column_next;
      token_length  <= token_length_next;
      seen_dot      <= seen_dot_next;
      keyword_match <= keyword_match_next;
      halted        <= halted_next;
    end
  end

  `STOK_ASSERT_NXT(a_halt_sticks, halted, halted)
  `STOK_ASSERT_IMP(a_halt_silent, halted, res.n == 2'd0)
  `STOK_ASSERT_IMP(a_pair_closes_token, res.n == 2'd2,
                   res.rec0.kind == stok_pkg::TK_IDENT || res.rec0.kind == stok_pkg::TK_LET ||
                   res.rec0.kind == stok_pkg::TK_PRINT || res.rec0.kind == stok_pkg::TK_NUMBER ||
                   res.rec0.kind == stok_pkg::TK_STRING)

endmodule

/* rtl/stok_fifo.sv */
// ----------------------------------------------------------------------------
// stok_fifo
// Small result queue: takes up to two records a cycle, gives one.
// ----------------------------------------------------------------------------
`include "source_tokenizer_assert.svh"

module stok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  stok_pkg::scan_out_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output stok_pkg::tok_rec_t  out_rec
);

  stok_pkg::tok_rec_t entry [stok_pkg::FIFO_DEPTH];
  stok_pkg::ptr_t     wr_ptr, rd_ptr;
  stok_pkg::cnt_t     count, count_next;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_rec   = entry[rd_ptr];
  // Room for the worst case of two records from one byte
  assign room      = (count <= stok_pkg::cnt_t'(stok_pkg::FIFO_DEPTH - 2));
  assign count_next = count + stok_pkg::cnt_t'(push.n) - stok_pkg::cnt_t'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entry[wr_ptr] <= push.rec0;
    end
    if (push.n == 2'd2) begin
      entry[wr_ptr + stok_pkg::ptr_t'(1)] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + stok_pkg::ptr_t'(push.n);
      rd_ptr <= rd_ptr + stok_pkg::ptr_t'(pop);
      count  <= count_next;
    end
  end

  `STOK_ASSERT_IMP(a_no_overflow, push.n != 2'd0,
                   count + stok_pkg::cnt_t'(push.n) <= stok_pkg::cnt_t'(stok_pkg::FIFO_DEPTH))

endmodule

/* rtl/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
// Feed one source byte per transfer; a zero byte or tuser set marks end of
// source, which flushes any open identifier, number or string and emits an
// eof record at the current position. Records come out with kind, error
// code, start line and column, value length and the offending byte; tlast
// marks the final record caused by a given byte. The block takes one byte
// per clock while the result queue has room: the byte is registered, decided
// combinationally, and its records are written into a four-entry result queue
// whose head drives the output. A byte that both closes a token and starts an
// operator, eof or error record yields two records, which leave the output
// one after the other; input is held back only while the queue has fewer
// than two free entries. After a double dot in a number or a byte that starts
// no token, an error record is emitted and every later byte is dropped
// without result until rst.
// ----------------------------------------------------------------------------
module source_tokenizer (
  input  logic        clk,
  input  logic        rst,
  // Source byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic [0:0]  s_tuser,   // [0] end_of_source
  // Token record stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [3:0] token_kind, [5:4] error_code,
                                 // [21:6] start_line, [37:22] start_column,
                                 // [53:38] value_length, [61:54] bad_char, [63:62] zero
  output logic        m_tlast    // last_of_run
);

  // Input register
  logic                in_valid;
  logic [7:0]          in_char;
  logic                in_eos;
  logic                fire;
  logic                room;
  logic                s_take;

  stok_pkg::scan_out_t scan_res;
  stok_pkg::tok_rec_t  out_rec;

  // Decide the held byte once the queue can take both of its possible records
  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;
  assign s_take   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // Payload: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (s_take) begin
      in_char <= s_tdata;
      in_eos  <= s_tuser[0];
    end
  end

  stok_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .char_code     (in_char),
    .end_of_source (in_eos),
    .res           (scan_res)
  );

  stok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (scan_res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec)
  );

  // Pack the record, first field in the lowest bits
  assign m_tdata = {2'b00, out_rec.bad, out_rec.len, out_rec.col, out_rec.line,
                    out_rec.err, out_rec.kind};
  assign m_tlast = out_rec.last;

endmodule

/* tb/sv/source_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// Self-checking bench for the streaming source tokenizer.
// ----------------------------------------------------------------------------
// Source bytes go in over the slave stream in random bursts while the master
// side stalls on shifting patterns. Every accepted byte is run through a
// behavioural tokenizer kept in the bench, and the token records it predicts
// are queued and compared field by field with each record that leaves the
// block. Directed cases cover keywords, every operator, literals and both
// ways of ending the source; a random program of well-formed tokens follows,
// and finally one error that halts the block.
// ----------------------------------------------------------------------------
module source_tokenizer_tb;

  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_LIMIT  = 5000;

  // Control and punctuation bytes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING} scan_t;

  // Progress through the keywords let and print
  typedef enum logic [3:0] {
    KW_START = 4'd0, KW_L = 4'd1, KW_LE = 4'd2, KW_LET = 4'd3,
    KW_P = 4'd4, KW_PR = 4'd5, KW_PRI = 4'd6, KW_PRIN = 4'd7,
    KW_PRINT = 4'd8, KW_MISS = 4'd15
  } kw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
  logic [0:0]  s_tuser = 1'b0;    // [0] end_of_source
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [3:0] kind, [5:4] error, [21:6] line,
                                  // [37:22] column, [53:38] length, [61:54] bad byte
  logic        m_tlast;

  source_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the tokenizer state, reset values as the block's
  scan_t            scan      = SCAN_IDLE;
  kw_t              kw        = KW_START;
  stok_pkg::line_t  line_cnt  = stok_pkg::line_t'(1);
  stok_pkg::col_t   col_cnt   = stok_pkg::col_t'(1);
  stok_pkg::line_t  tok_line  = '0;
  stok_pkg::col_t   tok_col   = '0;
  stok_pkg::len_t   tok_len   = '0;
  logic             dot_seen  = 1'b0;
  logic             halted    = 1'b0;

  stok_pkg::tok_rec_t tokens_due[$];   // records still owed by the block, oldest first
  int       mismatches = 0;
  int       bytes_sent = 0;
  int       burst_left = 0;
  int       hold_asks  = 0;    // long receiver hold-offs requested by the tests

  // --------------------------------------------------------------------------
  // Behavioural tokenizer
  // --------------------------------------------------------------------------
  function automatic logic [31:0] bump(input logic [31:0] v, input int w);
    logic [31:0] ceiling;
    ceiling = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    return (v >= ceiling) ? ceiling : v + 32'd1;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic stok_pkg::tok_kind_t operator_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:    return stok_pkg::TK_PLUS;
      CH_MINUS:   return stok_pkg::TK_MINUS;
      CH_STAR:    return stok_pkg::TK_STAR;
      CH_SLASH:   return stok_pkg::TK_SLASH;
      CH_PERCENT: return stok_pkg::TK_PERCENT;
      CH_EQUALS:  return stok_pkg::TK_ASSIGN;
      default:    return stok_pkg::TK_ERROR;
    endcase
  endfunction

  function automatic logic starts_token(input logic [7:0] c);
    return is_space(c) || is_letter(c) || is_digit(c) || c == CH_UNDER ||
           c == CH_QUOTE || operator_kind(c) != stok_pkg::TK_ERROR;
  endfunction

  function automatic kw_t kw_advance(input kw_t m, input logic [7:0] c);
    case (m)
      KW_START: return (c == "l") ? KW_L : ((c == "p") ? KW_P : KW_MISS);
      KW_L:     return (c == "e") ? KW_LE : KW_MISS;
      KW_LE:    return (c == "t") ? KW_LET : KW_MISS;
      KW_P:     return (c == "r") ? KW_PR : KW_MISS;
      KW_PR:    return (c == "i") ? KW_PRI : KW_MISS;
      KW_PRI:   return (c == "n") ? KW_PRIN : KW_MISS;
      KW_PRIN:  return (c == "t") ? KW_PRINT : KW_MISS;
      default:  return KW_MISS;
    endcase
  endfunction

  // Consume one byte: a newline opens the next line at column one
  function automatic void step_position(input logic [7:0] c);
    if (c == CH_NL) begin
      line_cnt = stok_pkg::line_t'(bump(32'(line_cnt), stok_pkg::LINE_WIDTH));
      col_cnt  = stok_pkg::col_t'(1);
    end else begin
      col_cnt = stok_pkg::col_t'(bump(32'(col_cnt), stok_pkg::COLUMN_WIDTH));
    end
  endfunction

  function automatic void open_token(input stok_pkg::len_t first_len);
    tok_line = line_cnt;
    tok_col  = col_cnt;
    tok_len  = first_len;
    dot_seen = 1'b0;
  endfunction

  function automatic void push_token(input stok_pkg::tok_kind_t k, input stok_pkg::tok_err_t e,
                                     input stok_pkg::line_t ln, input stok_pkg::col_t cl,
                                     input stok_pkg::len_t n, input logic [7:0] b);
    stok_pkg::tok_rec_t r;
    r.kind = k;
    r.err  = e;
    r.line = stok_pkg::field_t'(ln);
    r.col  = stok_pkg::field_t'(cl);
    r.len  = stok_pkg::field_t'(n);
    r.bad  = b;
    r.last = 1'b0;
    tokens_due.push_back(r);
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic eos_flag);
    logic                eos;
    logic                consumed;
    int                  owed_before;
    stok_pkg::tok_kind_t k;
    eos         = eos_flag || c == CH_NUL;
    consumed    = 1'b0;
    owed_before = tokens_due.size();
    if (halted) return;

    // Extend or close the open token first
    case (scan)
      SCAN_IDENT: begin
        if (!eos && (is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
          tok_len  = stok_pkg::len_t'(bump(32'(tok_len), stok_pkg::LENGTH_WIDTH));
          kw       = kw_advance(kw, c);
          step_position(c);
          consumed = 1'b1;
        end else begin
          k = (kw == KW_LET) ? stok_pkg::TK_LET :
              ((kw == KW_PRINT) ? stok_pkg::TK_PRINT : stok_pkg::TK_IDENT);
          push_token(k, stok_pkg::ERR_NONE, tok_line, tok_col, tok_len, 8'h00);
          scan = SCAN_IDLE;
        end
      end
      SCAN_NUMBER: begin
        if (!eos && (is_digit(c) || c == CH_UNDER || c == CH_DOT)) begin
          consumed = 1'b1;
          if (c == CH_DOT && dot_seen) begin
            push_token(stok_pkg::TK_ERROR, stok_pkg::ERR_TWO_DOTS, tok_line, tok_col, '0,
                       8'h00);
            halted = 1'b1;
          end else begin
            if (c == CH_DOT) dot_seen = 1'b1;
            if (c != CH_UNDER) begin
              tok_len = stok_pkg::len_t'(bump(32'(tok_len), stok_pkg::LENGTH_WIDTH));
            end
            step_position(c);
          end
        end else begin
          push_token(stok_pkg::TK_NUMBER, stok_pkg::ERR_NONE, tok_line, tok_col, tok_len,
                     8'h00);
          scan = SCAN_IDLE;
        end
      end
      SCAN_STRING: begin
        if (eos) begin
          // unterminated string closes at end of source
          push_token(stok_pkg::TK_STRING, stok_pkg::ERR_NONE, tok_line, tok_col, tok_len,
                     8'h00);
          scan = SCAN_IDLE;
        end else if (c == CH_QUOTE) begin
          step_position(c);
          push_token(stok_pkg::TK_STRING, stok_pkg::ERR_NONE, tok_line, tok_col, tok_len,
                     8'h00);
          scan     = SCAN_IDLE;
          consumed = 1'b1;
        end else begin
          tok_len  = stok_pkg::len_t'(bump(32'(tok_len), stok_pkg::LENGTH_WIDTH));
          step_position(c);
          consumed = 1'b1;
        end
      end
      default: ;
    endcase

    // Scan from idle whatever was not absorbed above
    if (!consumed) begin
      if (eos) begin
        push_token(stok_pkg::TK_EOF, stok_pkg::ERR_NONE, line_cnt, col_cnt, '0, 8'h00);
      end else if (is_space(c)) begin
        step_position(c);
      end else if (is_letter(c) || c == CH_UNDER) begin
        open_token(stok_pkg::len_t'(1));
        kw   = kw_advance(KW_START, c);
        scan = SCAN_IDENT;
        step_position(c);
      end else if (is_digit(c)) begin
        open_token(stok_pkg::len_t'(1));
        scan = SCAN_NUMBER;
        step_position(c);
      end else if (c == CH_QUOTE) begin
        open_token('0);
        scan = SCAN_STRING;
        step_position(c);
      end else begin
        k = operator_kind(c);
        if (k == stok_pkg::TK_ERROR) begin
          push_token(stok_pkg::TK_ERROR, stok_pkg::ERR_BAD_CHAR, line_cnt, col_cnt, '0, c);
          halted = 1'b1;
        end else begin
          push_token(k, stok_pkg::ERR_NONE, line_cnt, col_cnt, stok_pkg::len_t'(1), 8'h00);
          step_position(c);
        end
      end
    end

    if (tokens_due.size() > owed_before) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Source side: one byte per transfer, bursts with random gaps between them
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokenize_byte(c, eos);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall patterns, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int         served;
    int         held;
    int         window;
    int         phase;
    logic [7:0] pattern;
    served  = 0;
    window  = 0;
    phase   = 0;
    pattern = 8'hFF;
    forever begin
      @(posedge clk);
      if (hold_asks > served) begin
        served++;
        m_tready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0:       pattern = 8'hFF;                     // no stalls at all
          1:       pattern = 8'($urandom_range(1, 255));
          default: pattern = 8'h11;                     // mostly stalled
        endcase
      end
      m_tready <= pattern[phase];
      phase = (phase + 1) % 8;
      window--;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s, got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare every record that leaves the block with the oldest one owed
  always @(posedge clk) begin : record_check
    stok_pkg::tok_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected record", m_tdata, 64'd0);
      end else begin
        want = tokens_due.pop_front();
        if (m_tdata[3:0] != want.kind) begin
          report_mismatch("token_kind", 64'(m_tdata[3:0]), 64'(want.kind));
        end
        if (m_tdata[5:4] != want.err) begin
          report_mismatch("error_code", 64'(m_tdata[5:4]), 64'(want.err));
        end
        if (m_tdata[21:6] != want.line) begin
          report_mismatch("start_line", 64'(m_tdata[21:6]), 64'(want.line));
        end
        if (m_tdata[37:22] != want.col) begin
          report_mismatch("start_column", 64'(m_tdata[37:22]), 64'(want.col));
        end
        if (m_tdata[53:38] != want.len) begin
          report_mismatch("value_length", 64'(m_tdata[53:38]), 64'(want.len));
        end
        if (m_tdata[61:54] != want.bad) begin
          report_mismatch("bad_char", 64'(m_tdata[61:54]), 64'(want.bad));
        end
        if (m_tdata[63:62] != 2'b00) begin
          report_mismatch("tdata padding", 64'(m_tdata[63:62]), 64'd0);
        end
        if (m_tlast != want.last) begin
          report_mismatch("tlast", 64'(m_tlast), 64'(want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
  endfunction

  function automatic logic [7:0] word_char();
    int pick;
    pick = $urandom_range(0, 62);
    if (pick < 26) return 8'("a" + pick);
    if (pick < 52) return 8'("A" + pick - 26);
    if (pick < 62) return 8'("0" + pick - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] op_char(input int i);
    case (i)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PERCENT;
      default: return CH_EQUALS;
    endcase
  endfunction

  task automatic send_random_word();
    logic [7:0] first;
    if ($urandom_range(0, 4) == 0) begin
      // near misses on the keywords
      case ($urandom_range(0, 5))
        0:       send_text("le");
        1:       send_text("lets");
        2:       send_text("p");
        3:       send_text("prin");
        4:       send_text("printx");
        default: send_text("let_");
      endcase
    end else begin
      do first = word_char(); while (is_digit(first));
      send_byte(first, 1'b0);
    end
    repeat ($urandom_range(0, 5)) send_byte(word_char(), 1'b0);
  endtask

  task automatic send_random_number();
    logic dotted;
    int   pick;
    dotted = 1'b0;
    send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    repeat ($urandom_range(0, 7)) begin
      pick = $urandom_range(0, 19);
      if (pick < 3 && !dotted) begin
        send_byte(CH_DOT, 1'b0);
        dotted = 1'b1;
      end else if (pick < 6) begin
        send_byte(CH_UNDER, 1'b0);
      end else begin
        send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
    end
  endtask

  // Any byte but a quote or zero may sit inside a string, high bytes too
  task automatic send_random_string();
    logic [7:0] c;
    send_byte(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
      send_byte(c, 1'b0);
    end
    if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Both keywords, an underscore identifier ended by a newline, zero byte as eof
  task automatic test_keywords();
    send_text("let print _\n");
    send_byte(CH_NUL, 1'b0);
  endtask

  // Every operator but plus, a token closed by an operator, a number with underscore
  // and dot, a closed string, and an unterminated one flushed by tuser
  task automatic test_operators_and_literals();
    send_text("a=9_.5-\"q\"*/%");
    send_text("\"z");
    send_byte(8'hA7, 1'b1);
  endtask

  // Hold the result side off for a long stretch while operators keep coming,
  // so the result queue fills and input is held back
  task automatic test_output_backpressure();
    hold_asks++;
    for (int i = 0; i < 24; i++) send_byte(op_char(i % 6), 1'b0);
    send_byte(CH_NL, 1'b0);
  endtask

  task automatic test_random_program();
    int   start_count;
    int   pick;
    logic absorbs_digits;   // an open identifier or number would swallow a number
    start_count    = bytes_sent;
    absorbs_digits = 1'b0;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        if ($urandom_range(0, 1)) send_text("let");
        else send_text("print");
        absorbs_digits = 1'b1;
      end else if (pick < 30) begin
        send_random_word();
        absorbs_digits = 1'b1;
      end else if (pick < 50) begin
        // keep a second dot from joining onto the open token
        if (absorbs_digits) send_byte(blank_char(), 1'b0);
        send_random_number();
        absorbs_digits = 1'b1;
      end else if (pick < 62) begin
        send_random_string();
        absorbs_digits = 1'b0;
      end else if (pick < 87) begin
        send_byte(op_char($urandom_range(0, 5)), 1'b0);
        absorbs_digits = 1'b0;
      end else if (pick < 93) begin
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        else send_byte(CH_NUL, 1'b0);
        absorbs_digits = 1'b0;
      end else begin
        send_byte(CH_NL, 1'b0);
        absorbs_digits = 1'b0;
      end
      if ($urandom_range(0, 2) != 0) begin
        send_byte(blank_char(), 1'b0);
        absorbs_digits = 1'b0;
      end
    end
  endtask

  // One error ends scanning for good: a second dot in a number or a byte that
  // starts no token; every byte after it must be dropped silently. End of
  // source first closes whatever the random program left open.
  task automatic test_halt_after_error();
    logic [7:0] c;
    send_byte(CH_NUL, 1'b1);
    send_text(" ");
    if ($urandom_range(0, 1)) begin
      send_text("12.3_4.");
    end else begin
      if ($urandom_range(0, 1)) c = 8'($urandom_range(128, 255));
      else do c = 8'($urandom_range(1, 127)); while (starts_token(c));
      send_byte(c, 1'b0);
    end
    repeat (20) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_keywords();
    test_operators_and_literals();
    test_output_backpressure();
    test_random_program();
    test_halt_after_error();
    s_tvalid <= 1'b0;

    // Drain what is owed, then give the pipeline time to show any extras
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (tokens_due.size() != 0) begin
      report_mismatch("records never delivered", 64'(tokens_due.size()), 64'd0);
    end

    if (mismatches == 0) begin
      $display("source_tokenizer verification clean");
    end else begin
      $display("source_tokenizer verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #200us;
    $display("source_tokenizer verification failed");
    $finish;
  end

endmodule
